### hdl/osc_pkg.sv
// Package: shared types and constants for the ordered set ceiling/floor unit.
package osc_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     ceil_found;
    logic signed [DATA_W-1:0] ceil_value;
    logic                     floor_found;
    logic signed [DATA_W-1:0] floor_value;
    logic                     insert_dropped;
  } out_item_t;

  typedef struct packed {
    logic accept_ins;
    logic accept_qry;
    logic scan_rd;
    logic load_out;
  } osc_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } osc_stat_t;

endpackage

### hdl/ordered_set_ceil_floor_unit.sv
// Top level: bounded signed multiset with ceiling/floor queries.
// Insert: accept, then FIN hands off the result; one item in flight at a time.
// Query: SCAN reads one stored entry per cycle through a single memory read
// port and comparator, then DRAIN and FIN; an empty store skips to FIN.
// Reset (rst_n low, synchronous) empties the store and drops any pending item;
// store contents are not cleared, only the entry count.
module ordered_set_ceil_floor_unit
  import osc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  osc_cmd_t  cmd;
  osc_stat_t stat;

  osc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_item.req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  osc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

### hdl/osc_dp.sv
// Datapath: value store, scan index, ceiling/floor accumulators and result register.
module osc_dp
  import osc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  osc_cmd_t  cmd,
  input  in_item_t  in_item,
  output osc_stat_t stat,
  output out_item_t out_item
);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]         count_r;
  logic [ADDR_W-1:0]        idx_r;
  logic signed [DATA_W-1:0] key_r;
  logic                     qry_r;
  logic                     dropped_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     rd_vld_r;
  logic                     ceil_f_r, floor_f_r;
  logic signed [DATA_W-1:0] ceil_v_r, floor_v_r;
  out_item_t                out_r;

  logic                     full;
  logic                     ceil_hit, floor_hit;
  logic [CNT_W-1:0]         count_m1;

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign count_m1  = count_r - CNT_W'(1);
  assign stat.empty = (count_r == '0);
  assign stat.last  = ({1'b0, idx_r} == count_m1);

  assign ceil_hit  = rd_vld_r && (rd_data_r >= key_r) && (!ceil_f_r || rd_data_r < ceil_v_r);
  assign floor_hit = rd_vld_r && (rd_data_r <= key_r) && (!floor_f_r || rd_data_r > floor_v_r);

  always_ff @(posedge clk) begin
    if (cmd.accept_ins && !full) begin
      mem[count_r[ADDR_W-1:0]] <= in_item.value;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= $signed(mem[idx_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      ceil_f_r  <= 1'b0;
      floor_f_r <= 1'b0;
      qry_r     <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.accept_ins) begin
        qry_r     <= 1'b0;
        dropped_r <= full;
        if (!full) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.accept_qry) begin
        qry_r     <= 1'b1;
        dropped_r <= 1'b0;
        idx_r     <= '0;
        ceil_f_r  <= 1'b0;
        floor_f_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          idx_r <= idx_r + ADDR_W'(1);
        end
        if (ceil_hit) begin
          ceil_f_r <= 1'b1;
        end
        if (floor_hit) begin
          floor_f_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_qry) begin
      key_r <= in_item.value;
    end
    if (ceil_hit) begin
      ceil_v_r <= rd_data_r;
    end
    if (floor_hit) begin
      floor_v_r <= rd_data_r;
    end
    if (cmd.load_out) begin
      out_r.insert_dropped <= dropped_r;
      out_r.ceil_found     <= qry_r && ceil_f_r;
      out_r.ceil_value     <= (qry_r && ceil_f_r) ? ceil_v_r : '0;
      out_r.floor_found    <= qry_r && floor_f_r;
      out_r.floor_value    <= (qry_r && floor_f_r) ? floor_v_r : '0;
    end
  end

  assign out_item = out_r;

endmodule

### hdl/osc_ctrl.sv
// Controller: sequences accept, store scan and result hand-off.
module osc_ctrl
  import osc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  osc_stat_t stat,
  output osc_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire, slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd.accept_ins = 1'b0;
    cmd.accept_qry = 1'b0;
    cmd.scan_rd    = 1'b0;
    cmd.load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_QUERY) begin
            cmd.accept_qry = 1'b1;
            state_nxt      = stat.empty ? ST_FIN : ST_SCAN;
          end else begin
            cmd.accept_ins = 1'b1;
            state_nxt      = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/osc_checker.sv
// Checker: port-level properties of the ceiling/floor unit, bound to the top level.
module osc_port_checker
  import osc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn before accept");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item in flight");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.insert_dropped |-> !out_item.ceil_found && !out_item.floor_found)
    else $error("dropped insert carries query results");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ceil_found && out_item.floor_found
      |-> out_item.floor_value <= out_item.ceil_value)
    else $error("floor above ceiling");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_set_ceil_floor_unit osc_port_checker u_osc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
